// ===== design/ilc_pkg.sv =====
// Package for the indexed list with compaction.
// Holds the storage sizes, derived widths and the action and status codes.
// Depends on nothing; the interfaces, the top level and the testbench use it.
`default_nettype none

package ilc_pkg;

    localparam int MAX_ENTRIES      = 256;
    localparam int INITIAL_CAPACITY = 4;
    localparam int DATA_WIDTH       = 32;

    localparam int ADDR_W   = $clog2(MAX_ENTRIES);
    localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FIELD_W  = 9;
    localparam int CMP_W    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [INDEX_W-1:0]  t_index;
    typedef logic [VALUE_W-1:0]  t_value;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [FIELD_W-1:0]  t_field;

endpackage

`default_nettype wire

// ===== design/ilc_if.sv =====
// Valid/ready channel interfaces for the indexed list with compaction.
// The request channel carries one action; the response channel one result.
// Depends on ilc_pkg for the payload types.
`default_nettype none

interface ilc_req_if;
    logic            valid;
    logic            ready;
    ilc_pkg::t_action action;
    ilc_pkg::t_index  index;
    ilc_pkg::t_value  value;

    modport source (output valid, action, index, value, input ready);
    modport sink   (input valid, action, index, value, output ready);
endinterface

interface ilc_rsp_if;
    logic             valid;
    logic             ready;
    ilc_pkg::t_value  read_value;
    ilc_pkg::t_status status;
    ilc_pkg::t_field  element_count;
    ilc_pkg::t_field  capacity;

    modport source (output valid, read_value, status, element_count, capacity,
                    input ready);
    modport sink   (input valid, read_value, status, element_count, capacity,
                    output ready);
endinterface

`default_nettype wire

// ===== design/indexed_list_with_compaction.sv =====
// Top level of the indexed list with compaction: sequencer and entry memory.
// Depends on ilc_pkg and on the channel interfaces in ilc_if.sv.
//
// Requests arrive on i_req (action, index, value) and each one yields exactly
// one response on o_rsp (read_value, status, element_count, capacity). A
// transfer takes place on a clock edge with valid and ready both high.
// The entries live in a single memory with one write port and one read port
// whose read data is registered. One request is worked on at a time:
// append, overwrite and any refused request go through the finish state to
// the output register, a read through the read state first. A remove moves
// each later entry down one place, one entry per cycle through the memory in
// the shift state, and then passes through the finish state like the others.
// The response sits in an output register, so the next request is taken while
// an earlier response still waits; when the receiver stalls and a further
// response is ready, the sequencer holds it and stops taking requests.
// Reset clears the count to zero and sets the capacity to its initial value;
// the memory is not cleared, as only written entries are ever read.
`default_nettype none

module indexed_list_with_compaction (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ilc_req_if.sink     i_req,
    ilc_rsp_if.source   o_rsp
);
    import ilc_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [DATA_WIDTH-1:0] mem [MAX_ENTRIES];

    logic [1:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_cap, n_cap;
    logic [ADDR_W-1:0]     r_ptr, n_ptr;
    logic [DATA_WIDTH-1:0] r_res_val, n_res_val;
    t_status               r_res_status, n_res_status;
    logic                  r_out_valid, n_out_valid;
    t_value                r_out_val, n_out_val;
    t_status               r_out_status, n_out_status;
    t_field                r_out_count, n_out_count;
    t_field                r_out_cap, n_out_cap;
    logic [DATA_WIDTH-1:0] r_rdata;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [ADDR_W-1:0]     rd_addr;

    logic                  req_fire;
    logic [ADDR_W-1:0]     idx_addr;
    logic [CMP_W-1:0]      idx_c;
    logic [CMP_W-1:0]      cnt_c;
    logic                  in_range;
    logic                  can_append;
    logic [CNT_W:0]        cap_dbl;
    logic [CNT_W-1:0]      cap_grown;
    logic [CNT_W-1:0]      cnt_dec;
    logic [CNT_W-1:0]      ptr_next_c;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;

    assign idx_addr   = ADDR_W'(i_req.index);
    assign idx_c      = CMP_W'(i_req.index);
    assign cnt_c      = CMP_W'(r_count);
    assign in_range   = idx_c < cnt_c;
    assign can_append = r_count < CNT_W'(MAX_ENTRIES);
    assign cap_dbl    = {r_cap, 1'b0};
    assign cap_grown  = (cap_dbl > (CNT_W + 1)'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                              : CNT_W'(cap_dbl);
    assign cnt_dec    = r_count - CNT_W'(1);
    assign ptr_next_c = CNT_W'(r_ptr) + CNT_W'(1);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_cap        = r_cap;
        n_ptr        = r_ptr;
        n_res_val    = r_res_val;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_val    = r_out_val;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_cap    = r_out_cap;
        mem_we       = 1'b0;
        mem_waddr    = ADDR_W'(r_count);
        mem_wdata    = r_rdata;
        rd_addr      = idx_addr;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.action == ACT_REMOVE) begin
                    rd_addr = idx_addr + ADDR_W'(1);
                end
                if (req_fire) begin
                    n_res_val    = '0;
                    n_res_status = ST_DONE;
                    n_state      = S_FINISH;
                    unique case (i_req.action)
                        ACT_APPEND: begin
                            if (!can_append) begin
                                n_res_status = ST_FULL;
                            end else begin
                                if (r_count >= r_cap) begin
                                    n_cap = cap_grown;
                                end
                                mem_we    = 1'b1;
                                mem_waddr = ADDR_W'(r_count);
                                mem_wdata = DATA_WIDTH'(i_req.value);
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        ACT_READ: begin
                            if (!in_range) begin
                                n_res_status = ST_RANGE;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        ACT_WRITE: begin
                            if (!in_range) begin
                                n_res_status = ST_RANGE;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = idx_addr;
                                mem_wdata = DATA_WIDTH'(i_req.value);
                            end
                        end
                        ACT_REMOVE: begin
                            if (!in_range) begin
                                n_res_status = ST_RANGE;
                            end else begin
                                n_count = cnt_dec;
                                if (cnt_dec != '0 && cnt_dec == (r_cap >> 2)) begin
                                    n_cap = r_cap >> 1;
                                end
                                if ((idx_c + CMP_W'(1)) < cnt_c) begin
                                    n_ptr   = idx_addr;
                                    n_state = S_SHIFT;
                                end
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res_val = r_rdata;
                n_state   = S_FINISH;
            end
            S_SHIFT: begin
                // The entry above the pointer was read last cycle; the next one is read now.
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                mem_wdata = r_rdata;
                rd_addr   = r_ptr + ADDR_W'(2);
                if (ptr_next_c < r_count) begin
                    n_ptr = r_ptr + ADDR_W'(1);
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_val    = VALUE_W'(r_res_val);
                    n_out_status = r_res_status;
                    n_out_count  = FIELD_W'(r_count);
                    n_out_cap    = FIELD_W'(r_cap);
                    n_state      = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cap       <= CNT_W'(INITIAL_CAPACITY);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cap       <= n_cap;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_res_val    <= n_res_val;
        r_res_status <= n_res_status;
        r_out_val    <= n_out_val;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_cap    <= n_out_cap;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.read_value    = r_out_val;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.element_count = r_out_count;
    assign o_rsp.capacity      = r_out_cap;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for indexed_list_with_compaction: directed and random list actions on the
// request channel, with every response checked against a behavioural model of the list.
// Depends on ilc_pkg, the channel interfaces in ilc_if.sv and the design top level.
`timescale 1ns / 100ps

module testbench;
    import ilc_pkg::*;

    localparam int TIMEOUT_CYCLES = 1_500_000;
    localparam int SETTLE_CYCLES  = 300;
    localparam int IDLE_PERCENT   = 23;

    typedef struct packed {
        t_value  read_value;
        t_status status;
        t_field  element_count;
        t_field  capacity;
    } t_list_result;

    logic i_clk;
    logic i_rst_n;

    ilc_req_if req_ch ();
    ilc_rsp_if rsp_ch ();

    indexed_list_with_compaction dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_value       list_words [MAX_ENTRIES];
    int           list_count;
    int           list_cap;
    t_list_result pending_results [$];
    t_list_result expected_result;
    int           error_count = 0;
    int           cycle_count = 0;
    bit           idle_on;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_list_result apply_list_action(t_action act, t_index idx, t_value val);
        t_list_result res;
        int           i;
        res.read_value = '0;
        res.status     = ST_DONE;
        if (act == ACT_APPEND) begin
            if (list_count >= MAX_ENTRIES) begin
                res.status = ST_FULL;
            end else begin
                if (list_count >= list_cap) begin
                    list_cap = (list_cap * 2 > MAX_ENTRIES) ? MAX_ENTRIES : list_cap * 2;
                end
                list_words[list_count] = val;
                list_count++;
            end
        end else if (int'(idx) >= list_count) begin
            res.status = ST_RANGE;
        end else if (act == ACT_READ) begin
            res.read_value = list_words[idx];
        end else if (act == ACT_WRITE) begin
            list_words[idx] = val;
        end else begin
            for (i = int'(idx); i + 1 < list_count; i++) begin
                list_words[i] = list_words[i + 1];
            end
            list_count--;
            if (list_count > 0 && list_count == list_cap / 4) begin
                list_cap = list_cap / 2;
            end
        end
        res.element_count = t_field'(list_count);
        res.capacity      = t_field'(list_cap);
        return res;
    endfunction

    // Entered and left at a falling edge; valid stays high for a following transfer.
    task automatic send_item(t_action act, t_index idx, t_value val);
        while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid  = 1'b1;
        req_ch.action = act;
        req_ch.index  = idx;
        req_ch.value  = val;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        pending_results.push_back(apply_list_action(act, idx, val));
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        req_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_empty_list();
        send_item(ACT_READ, 8'd0, 32'h0);
        send_item(ACT_WRITE, 8'hFF, 32'hFFFF_FFFF);
        send_item(ACT_REMOVE, 8'd0, 32'h0);
    endtask

    task automatic test_growth();
        send_item(ACT_APPEND, 8'd0, 32'h0000_0000);
        send_item(ACT_APPEND, 8'hFF, 32'hFFFF_FFFF);
        send_item(ACT_APPEND, 8'd0, 32'hA5A5_A5A5);
        send_item(ACT_APPEND, 8'd0, 32'h5A5A_5A5A);
        send_item(ACT_APPEND, 8'd0, 32'h0000_0001);
    endtask

    task automatic test_read_write();
        send_item(ACT_READ, 8'd0, 32'hFFFF_FFFF);
        send_item(ACT_READ, 8'd4, 32'h0);
        send_item(ACT_READ, 8'd5, 32'h0);
        send_item(ACT_WRITE, 8'd4, 32'hFFFF_FFFF);
        send_item(ACT_WRITE, 8'd0, 32'h0);
        send_item(ACT_WRITE, 8'd5, 32'h1234_5678);
        send_item(ACT_READ, 8'd4, 32'h0);
    endtask

    // Also covers the small capacity, where a quarter rounds down to zero.
    task automatic test_remove_and_shrink();
        send_item(ACT_REMOVE, 8'd0, 32'h0);
        send_item(ACT_REMOVE, 8'd3, 32'h0);
        send_item(ACT_REMOVE, 8'd1, 32'h0);
        send_item(ACT_REMOVE, 8'd0, 32'h0);
        send_item(ACT_APPEND, 8'd0, 32'hDEAD_BEEF);
        send_item(ACT_REMOVE, 8'd1, 32'h0);
        send_item(ACT_APPEND, 8'd0, 32'h8000_0000);
        send_item(ACT_APPEND, 8'd0, 32'h7FFF_FFFF);
        send_item(ACT_READ, 8'd2, 32'h0);
        send_item(ACT_REMOVE, 8'd0, 32'h0);
        send_item(ACT_REMOVE, 8'd0, 32'h0);
        send_item(ACT_REMOVE, 8'd0, 32'h0);
    endtask

    task automatic test_random_actions(int n_items);
        t_action act;
        t_index  idx;
        int      pick;
        repeat (n_items) begin
            pick = $urandom_range(99);
            if (list_count == 0) begin
                act = (pick < 75) ? ACT_APPEND : t_action'($urandom_range(3));
            end else if (list_count > 48) begin
                act = (pick < 15) ? ACT_APPEND : (pick < 40) ? ACT_READ :
                      (pick < 60) ? ACT_WRITE : ACT_REMOVE;
            end else begin
                act = (pick < 35) ? ACT_APPEND : (pick < 60) ? ACT_READ :
                      (pick < 80) ? ACT_WRITE : ACT_REMOVE;
            end
            if (list_count > 0 && $urandom_range(99) < 85) begin
                idx = t_index'($urandom_range(list_count - 1));
            end else begin
                idx = t_index'($urandom_range(255));
            end
            send_item(act, idx, $urandom());
        end
    endtask

    task automatic test_fill_and_drain();
        while (list_count < MAX_ENTRIES) begin
            send_item(ACT_APPEND, t_index'($urandom_range(255)), $urandom());
        end
        send_item(ACT_APPEND, 8'd0, 32'hFFFF_FFFF);
        send_item(ACT_APPEND, 8'hFF, $urandom());
        send_item(ACT_READ, 8'hFF, 32'h0);
        send_item(ACT_WRITE, 8'hFF, $urandom());
        send_item(ACT_READ, 8'hFF, 32'h0);
        send_item(ACT_REMOVE, 8'd0, 32'h0);
        send_item(ACT_REMOVE, 8'd0, 32'h0);
        while (list_count > 0) begin
            if ($urandom_range(3) == 0) begin
                send_item(ACT_READ, t_index'($urandom_range(list_count - 1)), $urandom());
            end
            send_item(ACT_REMOVE,
                      t_index'(list_count - 1 - $urandom_range(list_count > 4 ? 3 : 0)),
                      $urandom());
        end
    endtask

    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready = !(idle_on && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("unexpected transfer: read_value %h status %0d count %0d capacity %0d",
                       rsp_ch.read_value, rsp_ch.status, rsp_ch.element_count,
                       rsp_ch.capacity);
                error_count++;
            end else begin
                expected_result = pending_results.pop_front();
                if (rsp_ch.read_value !== expected_result.read_value) begin
                    $error("read_value: expected %h, actual %h",
                           expected_result.read_value, rsp_ch.read_value);
                    error_count++;
                end
                if (rsp_ch.status !== expected_result.status) begin
                    $error("status: expected %0d, actual %0d",
                           expected_result.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.element_count !== expected_result.element_count) begin
                    $error("element_count: expected %0d, actual %0d",
                           expected_result.element_count, rsp_ch.element_count);
                    error_count++;
                end
                if (rsp_ch.capacity !== expected_result.capacity) begin
                    $error("capacity: expected %0d, actual %0d",
                           expected_result.capacity, rsp_ch.capacity);
                    error_count++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < TIMEOUT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench failed");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.action = ACT_APPEND;
        req_ch.index  = '0;
        req_ch.value  = '0;
        idle_on       = 1'b1;
        list_count    = 0;
        list_cap      = INITIAL_CAPACITY;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_list();
        test_growth();
        test_read_write();
        test_remove_and_shrink();
        test_random_actions(250);
        wait_for_results();
        idle_on = 1'b0;
        test_random_actions(150);
        idle_on = 1'b1;
        test_random_actions(100);
        test_fill_and_drain();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// ===== indexed_list_with_compaction.f =====
design/ilc_pkg.sv
design/ilc_if.sv
design/indexed_list_with_compaction.sv
test/testbench.sv
